// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros used by hash_verdict_cache.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/hvc_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hvc_pkg
// Shared widths, field offsets and the result type of the hash verdict cache.
// ---------------------------------------------------------------------------
package hvc_pkg;

	localparam int LEN_W       = 6;    // key length field
	localparam int CAP_W       = 7;    // capacity register
	localparam int WORD_W      = 64;   // one key word
	localparam int WORDS       = 4;    // key words per transaction
	localparam int KEY_W       = WORD_W * WORDS;
	localparam int IN_W        = 264;  // input tdata, byte padded
	localparam int OUT_W       = 8;    // output tdata, byte padded

	// input tdata field positions
	localparam int LEN_LSB     = 0;
	localparam int KEY_LSB     = LEN_LSB + LEN_W;
	localparam int VERDICT_BIT = KEY_LSB + KEY_W;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	// one result transaction, hit in the lowest bit
	typedef struct packed {
		logic stored;
		logic cached_verdict;
		logic hit;
	} res_t;

endpackage

// ----- design/hvc_store.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hvc_store
// Single-port-write, single-port-read entry memory, registered read data.
// ---------------------------------------------------------------------------
module hvc_store #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 263,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- design/hvc_scan.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hvc_scan
// Lookup/insert sequencer: streams entries out of the store, compares one
// per cycle, and on an insert miss writes the key at the ring pointer.
// ---------------------------------------------------------------------------
module hvc_scan #(
	parameter int ENTRIES   = 64,
	parameter int KEY_BYTES = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [hvc_pkg::CAP_W-1:0]  capacity,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       in_kind,
	input  logic [hvc_pkg::LEN_W-1:0]  in_len,
	input  logic [hvc_pkg::KEY_W-1:0]  in_key,
	input  logic                       in_verdict,
	output logic                       res_valid,
	input  logic                       res_ready,
	output hvc_pkg::res_t              res
);

	localparam int AW   = $clog2(ENTRIES);
	localparam int CW   = $clog2(ENTRIES + 1);
	localparam int KB   = KEY_BYTES * 8;
	localparam int EW   = KB + hvc_pkg::LEN_W + 1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]                  state_q;
	logic [AW-1:0]               wp_q;
	logic [CW-1:0]               vc_q;
	logic [CW-1:0]               iss_q;
	logic                        rvalid_s1;

	logic [KB-1:0]               key_q;
	logic [hvc_pkg::LEN_W-1:0]   len_q;
	logic                        kind_q;
	logic                        verdict_q;
	logic [CW-1:0]               cap_q;
	logic [CW-1:0]               lim_q;
	hvc_pkg::res_t               res_q;

	logic [hvc_pkg::LEN_W-1:0]   len_sat;
	logic [KB-1:0]               key_masked;
	logic [CW-1:0]               eff_cap;
	logic                        accept;
	logic                        rd_en;
	logic [EW-1:0]               rd_data;
	logic                        hit_now;
	logic                        miss_now;
	logic                        wr_en;
	logic [AW-1:0]               wr_at;
	logic [CW-1:0]               wr_next;
	logic [EW-1:0]               wr_data;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);

	// saturate length and clear bytes past it
	always_comb begin
		len_sat = (int'(in_len) > KEY_BYTES) ? hvc_pkg::LEN_W'(KEY_BYTES) : in_len;
		for (int b = 0; b < KEY_BYTES; b++) begin
			key_masked[b*8 +: 8] = (b < int'(len_sat)) ? in_key[b*8 +: 8] : 8'h00;
		end
	end

	// effective capacity: zero acts as one, clipped to the memory depth
	always_comb begin
		if (capacity == '0) begin
			eff_cap = CW'(1);
		end else if (int'(capacity) > ENTRIES) begin
			eff_cap = CW'(ENTRIES);
		end else begin
			eff_cap = CW'(capacity);
		end
	end

	// read issue and compare of the entry returned last cycle
	assign rd_en    = (state_q == S_SCAN) && (iss_q < lim_q);
	assign hit_now  = (state_q == S_SCAN) && rvalid_s1 &&
	                  (rd_data[KB +: hvc_pkg::LEN_W] == len_q) &&
	                  (rd_data[KB-1:0] == key_q);
	assign miss_now = (state_q == S_SCAN) && !hit_now && !rd_en && !rvalid_s1;

	// insert slot: pointer restarts at zero if capacity fell to or below it
	assign wr_at   = (CW'(wp_q) >= cap_q) ? '0 : wp_q;
	assign wr_next = CW'(wr_at) + CW'(1);
	assign wr_en   = miss_now && kind_q;
	assign wr_data = {verdict_q, len_q, key_q};

	hvc_store #(
		.DEPTH (ENTRIES),
		.WIDTH (EW)
	) u_store (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (iss_q[AW-1:0]),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_at),
		.wr_data (wr_data)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			wp_q      <= '0;
			vc_q      <= '0;
			iss_q     <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					iss_q     <= '0;
					rvalid_s1 <= 1'b0;
					if (accept) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (hit_now || miss_now) begin
						state_q <= S_DONE;
					end else begin
						iss_q     <= iss_q + CW'(rd_en);
						rvalid_s1 <= rd_en;
					end
					if (wr_en) begin
						wp_q <= (wr_next >= cap_q) ? '0 : wr_next[AW-1:0];
						if (vc_q < wr_next) begin
							vc_q <= wr_next;
						end
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// transaction payload and result
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q     <= key_masked;
			len_q     <= len_sat;
			kind_q    <= in_kind;
			verdict_q <= in_verdict;
			cap_q     <= eff_cap;
			lim_q     <= (vc_q < eff_cap) ? vc_q : eff_cap;
		end
		if (hit_now) begin
			res_q.hit            <= 1'b1;
			res_q.cached_verdict <= rd_data[EW-1];
			res_q.stored         <= 1'b0;
		end else if (miss_now) begin
			res_q.hit            <= 1'b0;
			res_q.cached_verdict <= 1'b0;
			res_q.stored         <= kind_q;
		end
	end

	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

endmodule

// ----- design/hash_verdict_cache.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hash_verdict_cache
// FIFO-replacement lookup cache of hash keys with a one-bit verdict each.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream carries one lookup (tuser 0) or insert (tuser 1) per
//   transaction; master stream returns exactly one result per transaction
//   (hit, cached verdict, stored). The cfg channel writes the capacity
//   register and is always ready; write it only while the cache is idle.
// Sequencing:
//   One transaction at a time. A miss scans min(valid entries, capacity)
//   entries before its result reaches the output register; a hit on entry
//   k stops the scan there. The one-entry-per-cycle read port of the entry
//   memory sets the scan time. The next transaction is accepted the cycle
//   after the result moves into the output register.
// Reset:
//   arst_n clears pointer, valid count and handshakes; capacity returns to
//   64. Entry memory is not cleared: only written entries are ever scanned.
// Stalls:
//   The output register holds a result while m_tready is low; one further
//   transaction may be accepted and scanned, then waits for the register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hash_verdict_cache #(
	parameter int ENTRIES   = 64,
	parameter int KEY_BYTES = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// capacity register write
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [hvc_pkg::CAP_W-1:0]  cfg_data,
	// slave stream
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [hvc_pkg::IN_W-1:0]   s_tdata,  // key_length, key_word0..3, new_verdict, pad
	input  logic [0:0]                 s_tuser,  // kind
	// master stream
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [hvc_pkg::OUT_W-1:0]  m_tdata   // hit, cached_verdict, stored, pad
);

	logic [hvc_pkg::CAP_W-1:0] capacity_q;
	logic                      res_valid;
	logic                      res_ready;
	hvc_pkg::res_t             res;
	hvc_pkg::res_t             m_res_q;
	logic                      m_tvalid_q;

	// capacity register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= hvc_pkg::CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	// lookup / insert engine
	hvc_scan #(
		.ENTRIES   (ENTRIES),
		.KEY_BYTES (KEY_BYTES)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.capacity   (capacity_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_kind    (s_tuser[0]),
		.in_len     (s_tdata[hvc_pkg::LEN_LSB +: hvc_pkg::LEN_W]),
		.in_key     (s_tdata[hvc_pkg::KEY_LSB +: hvc_pkg::KEY_W]),
		.in_verdict (s_tdata[hvc_pkg::VERDICT_BIT]),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	// output register
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(hvc_pkg::OUT_W - $bits(hvc_pkg::res_t))'(0), m_res_q};

	// checks
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready,
		"cache accepted a transaction while scanning")
	`ASSERT_NEXT(a_result_registered, clk, arst_n, res_valid && res_ready, m_tvalid_q,
		"result lost on its way to the output register")
	`ASSERT_SAME(a_stored_only_on_miss, clk, arst_n, m_tvalid_q, !(m_res_q.hit && m_res_q.stored),
		"insert stored a key that already hit")
	`ASSERT_SAME(a_miss_verdict_zero, clk, arst_n, m_tvalid_q && !m_res_q.hit,
		!m_res_q.cached_verdict, "miss returned a nonzero verdict")

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the hash verdict cache: a directed table, then
// random lookups and inserts across several capacity settings. Results are
// checked against typed-in outcomes or a behavioral bench copy of the cache.
// ---------------------------------------------------------------------------
module testbench;

	localparam int LEN_W       = hvc_pkg::LEN_W;
	localparam int KEY_W       = hvc_pkg::KEY_W;
	localparam int CAP_W       = hvc_pkg::CAP_W;
	localparam int IN_W        = hvc_pkg::IN_W;
	localparam int OUT_W       = hvc_pkg::OUT_W;
	localparam int LEN_LSB     = hvc_pkg::LEN_LSB;
	localparam int KEY_LSB     = hvc_pkg::KEY_LSB;
	localparam int VERDICT_BIT = hvc_pkg::VERDICT_BIT;

	typedef hvc_pkg::res_t res_t;

	localparam int ENTRIES   = 64;
	localparam int KEY_BYTES = 32;
	localparam int CYCLE_LIMIT = 600000;
	localparam int LONG_HOLD   = 300;
	localparam int REPORT_MAX  = 10;
	localparam int POOL_MAX    = 96;

	typedef enum logic {LOOKUP = 1'b0, INSERT = 1'b1} access_kind_t;

	typedef struct packed {
		access_kind_t     kind;
		logic [LEN_W-1:0] len;
		logic [KEY_W-1:0] key;
		logic             verdict;
	} cache_req_t;

	// directed row: request, whether the result is typed in, and that result
	typedef struct packed {
		cache_req_t req;
		logic       typed;
		res_t       outcome;
	} dir_row_t;

	localparam logic [KEY_W-1:0] ONES  = {KEY_W{1'b1}};
	localparam logic [KEY_W-1:0] ZEROS = {KEY_W{1'b0}};
	localparam logic [KEY_W-1:0] JUNK  = {4{64'h0123_4567_89AB_CDEF}};
	localparam logic [KEY_W-1:0] ALT5  = {4{64'h5555_5555_5555_5555}};
	localparam logic [KEY_W-1:0] ALTA  = {4{64'hAAAA_AAAA_AAAA_AAAA}};

	localparam int DIR_ROWS = 20;
	dir_row_t dir_table [DIR_ROWS] = '{
		// empty cache, full-length key of all ones
		'{'{LOOKUP, 6'd32, ONES, 1'b0}, 1'b1, 3'b000},
		'{'{INSERT, 6'd32, ONES, 1'b1}, 1'b1, 3'b100},
		'{'{LOOKUP, 6'd32, ONES, 1'b0}, 1'b1, 3'b011},
		// present key: hit, stored verdict unchanged
		'{'{INSERT, 6'd32, ONES, 1'b0}, 1'b1, 3'b011},
		// empty key
		'{'{LOOKUP, 6'd0, ZEROS, 1'b0}, 1'b1, 3'b000},
		'{'{INSERT, 6'd0, ZEROS, 1'b0}, 1'b1, 3'b100},
		'{'{LOOKUP, 6'd0, JUNK, 1'b1}, 1'b1, 3'b001},
		// long keys saturate to 32 bytes
		'{'{INSERT, 6'd63, ONES, 1'b0}, 1'b1, 3'b011},
		'{'{LOOKUP, 6'd33, ONES, 1'b0}, 1'b1, 3'b011},
		// bytes past the length are ignored
		'{'{INSERT, 6'd1, {{31{8'h3C}}, 8'hAB}, 1'b1}, 1'b0, 3'b000},
		'{'{LOOKUP, 6'd1, {{31{8'hC3}}, 8'hAB}, 1'b0}, 1'b0, 3'b000},
		'{'{LOOKUP, 6'd2, {{30{8'h00}}, 8'h11, 8'hAB}, 1'b0}, 1'b0, 3'b000},
		'{'{INSERT, 6'd8, {{24{8'h77}}, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b0}, 1'b0, 3'b000},
		'{'{LOOKUP, 6'd8, {192'h0, 64'h00FF_FFFF_FFFF_FFFF}, 1'b1}, 1'b0, 3'b000},
		'{'{INSERT, 6'd31, ALT5, 1'b1}, 1'b0, 3'b000},
		'{'{LOOKUP, 6'd31, {8'h00, {31{8'h55}}}, 1'b0}, 1'b0, 3'b000},
		'{'{LOOKUP, 6'd32, ALT5, 1'b0}, 1'b0, 3'b000},
		'{'{INSERT, 6'd16, ZEROS, 1'b1}, 1'b0, 3'b000},
		'{'{INSERT, 6'd24, ALTA, 1'b0}, 1'b0, 3'b000},
		'{'{LOOKUP, 6'd24, {{8{8'hFF}}, {24{8'hAA}}}, 1'b1}, 1'b0, 3'b000}
	};

	// random phases: capacity written before the phase, items, insert share
	localparam int PHASES = 10;
	localparam int PHASE_CAP [PHASES] = '{1, 0, 127, 7, 64, 3, 65, 2, 33, 64};
	localparam int PHASE_LEN [PHASES] = '{40, 30, 110, 50, 60, 40, 60, 30, 40, 40};
	localparam int PHASE_INS [PHASES] = '{50, 50, 80, 50, 40, 50, 60, 50, 50, 50};

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CAP_W-1:0]  cfg_data;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;   // key_length, key_word0..3, new_verdict, pad
	logic [0:0]        s_tuser;   // kind
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;   // hit, cached_verdict, stored, pad

	hash_verdict_cache #(
		.ENTRIES  (ENTRIES),
		.KEY_BYTES(KEY_BYTES)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// cache contents as the bench sees them
	logic [KEY_W-1:0] key_mem     [ENTRIES];
	logic [LEN_W-1:0] len_mem     [ENTRIES];
	logic             verdict_mem [ENTRIES];
	int               wr_ptr;
	int               filled;
	logic [CAP_W-1:0] capacity_reg;

	res_t       pending_outcomes [$];
	cache_req_t known_keys [$];
	int         err_count;
	int         burst_left;
	int         hold_requests;
	int         cycle_count;

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	// byte mask covering the first len bytes of a key
	function automatic logic [KEY_W-1:0] len_mask(input logic [LEN_W-1:0] len);
		logic [KEY_W-1:0] m;
		int b;
		m = '0;
		for (b = 0; b < KEY_BYTES; b++)
			if (b < len) m[8*b +: 8] = 8'hFF;
		return m;
	endfunction

	function automatic logic [KEY_W-1:0] random_key();
		logic [KEY_W-1:0] k;
		int i;
		for (i = 0; i < KEY_W / 32; i++) k[32*i +: 32] = $urandom;
		return k;
	endfunction

	// lookup or insert against the bench copy of the cache
	function automatic res_t cache_access(input cache_req_t r);
		logic [LEN_W-1:0] len;
		logic [KEY_W-1:0] key;
		int cap, lim, at, e;
		res_t res;
		len = (r.len > KEY_BYTES) ? LEN_W'(KEY_BYTES) : r.len;
		key = r.key & len_mask(len);
		cap = (capacity_reg == 0) ? 1 : (capacity_reg > ENTRIES) ? ENTRIES : capacity_reg;
		lim = (filled < cap) ? filled : cap;
		res = '0;
		// first matching entry wins
		for (e = 0; e < lim && !res.hit; e++) begin
			if (len_mem[e] == len && key_mem[e] == key) begin
				res.hit = 1'b1;
				res.cached_verdict = verdict_mem[e];
			end
		end
		// new key goes in at the ring pointer
		if (r.kind == INSERT && !res.hit) begin
			at = (wr_ptr >= cap) ? 0 : wr_ptr;
			key_mem[at] = key;
			len_mem[at] = len;
			verdict_mem[at] = r.verdict;
			if (filled < at + 1) filled = at + 1;
			wr_ptr = (at + 1 >= cap) ? 0 : at + 1;
			res.stored = 1'b1;
		end
		return res;
	endfunction

	// random request: mostly keys seen before, some near misses, some fresh
	function automatic cache_req_t make_request(input int insert_pct);
		cache_req_t r;
		logic [KEY_W-1:0] m;
		int pick, bitpos;
		r.kind = ($urandom_range(99) < insert_pct) ? INSERT : LOOKUP;
		r.verdict = 1'($urandom_range(1));
		pick = $urandom_range(99);
		if (pick < 65 && known_keys.size() != 0) begin
			r.len = known_keys[$urandom_range(known_keys.size() - 1)].len;
			r.key = known_keys[$urandom_range(known_keys.size() - 1)].key;
			r = known_keys[$urandom_range(known_keys.size() - 1)];
			r.kind = ($urandom_range(99) < insert_pct) ? INSERT : LOOKUP;
			r.verdict = 1'($urandom_range(1));
			// junk past the length must not matter
			m = len_mask(r.len);
			r.key = (r.key & m) | (random_key() & ~m);
			if (r.len >= KEY_BYTES && $urandom_range(3) == 0)
				r.len = LEN_W'($urandom_range(KEY_BYTES, 63));
			if (pick >= 45) begin
				// near miss: one bit inside the key, or the length
				if (r.len != 0 && $urandom_range(1)) begin
					bitpos = $urandom_range(8 * ((r.len > KEY_BYTES) ? KEY_BYTES : r.len) - 1);
					r.key[bitpos] = ~r.key[bitpos];
				end else begin
					r.len = LEN_W'((r.len == 0 || $urandom_range(1)) ? r.len + 1 : r.len - 1);
				end
			end
		end else begin
			pick = $urandom_range(99);
			r.len = (pick < 5) ? 6'd0 : (pick < 20) ? LEN_W'($urandom_range(KEY_BYTES + 1, 63)) :
				LEN_W'($urandom_range(1, KEY_BYTES));
			r.key = random_key();
		end
		if (r.kind == INSERT) begin
			if (known_keys.size() >= POOL_MAX)
				known_keys.delete($urandom_range(known_keys.size() - 1));
			known_keys.push_back(r);
		end
		return r;
	endfunction

	task automatic log_mismatch(input string what, input res_t want, input res_t seen);
		err_count++;
		if (err_count <= REPORT_MAX)
			$display("%0t %s: expected hit=%0b verdict=%0b stored=%0b, got hit=%0b verdict=%0b stored=%0b",
				$realtime, what, want.hit, want.cached_verdict, want.stored,
				seen.hit, seen.cached_verdict, seen.stored);
	endtask

	// offer one request in bursts with random gaps; record what it should return
	task automatic offer_item(input cache_req_t r, input logic typed, input res_t typed_res);
		logic [IN_W-1:0] word;
		int gap;
		res_t res;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(3) == 0) ? 0 :
				($urandom_range(7) == 0) ? $urandom_range(10, 90) : $urandom_range(1, 9);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		word = '0;
		word[LEN_LSB +: LEN_W] = r.len;
		word[KEY_LSB +: KEY_W] = r.key;
		word[VERDICT_BIT] = r.verdict;
		s_tvalid <= 1'b1;
		s_tdata <= word;
		s_tuser <= r.kind;
		do @(posedge clk); while (!s_tready);
		res = cache_access(r);
		pending_outcomes.push_back(typed ? typed_res : res);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_outcomes.size() != 0) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		capacity_reg = value;
	endtask

	// result sink: its own stall pattern, plus long hold-offs on request
	initial begin : result_sink
		int hold_left, mode, mode_left, holds_served;
		logic [7:0] pattern;
		res_t seen, want;
		m_tready = 1'b0;
		hold_left = 0;
		mode = 0;
		mode_left = 0;
		holds_served = 0;
		pattern = 8'hFF;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				seen = res_t'(m_tdata[2:0]);
				if (pending_outcomes.size() == 0) begin
					log_mismatch("unexpected result", '0, seen);
				end else begin
					want = pending_outcomes.pop_front();
					if (seen.hit !== want.hit || seen.cached_verdict !== want.cached_verdict ||
						seen.stored !== want.stored)
						log_mismatch("result mismatch", want, seen);
				end
			end
			if (holds_served != hold_requests) begin
				holds_served++;
				hold_left = LONG_HOLD;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(3);
				mode_left = $urandom_range(20, 120);
				pattern = 8'($urandom);
			end
			mode_left--;
			pattern = {pattern[6:0], pattern[7]};
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(1));
					2: m_tready <= ($urandom_range(3) == 0);
					default: m_tready <= pattern[0];
				endcase
			end
		end
	end

	// stimulus
	initial begin : stimulus
		int i, p;
		cache_req_t r;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		err_count = 0;
		burst_left = 0;
		hold_requests = 0;
		wr_ptr = 0;
		filled = 0;
		capacity_reg = hvc_pkg::CAP_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at the reset capacity
		for (i = 0; i < DIR_ROWS; i++)
			offer_item(dir_table[i].req, dir_table[i].typed, dir_table[i].outcome);
		wait_drained();

		// random phases, each at its own capacity, cache idle between them
		for (p = 0; p < PHASES; p++) begin
			write_capacity(CAP_W'(PHASE_CAP[p]));
			if (p == 2 || p == 6) hold_requests++;
			for (i = 0; i < PHASE_LEN[p]; i++) begin
				r = make_request(PHASE_INS[p]);
				offer_item(r, 1'b0, '0);
			end
			wait_drained();
		end

		// let any stray result show up
		repeat (80) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+design
design/hvc_pkg.sv
design/hvc_store.sv
design/hvc_scan.sv
design/hash_verdict_cache.sv
sim/testbench.sv
